>>> rtl/comment_skipping_tokenizer_assert.svh
// Assertion macros shared by the comment-skipping tokenizer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef COMMENT_SKIPPING_TOKENIZER_ASSERT_SVH
`define COMMENT_SKIPPING_TOKENIZER_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define CST_ASSERT_ALWAYS(lbl, clk_s, rstn_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (expr)) \
    else $error("assertion failed: lbl");

// Antecedent this cycle implies consequent in the next cycle.
`define CST_ASSERT_NEXT(lbl, clk_s, rstn_s, pre, post) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |=> (post)) \
    else $error("assertion failed: lbl");

`endif

>>> rtl/cst_pkg.sv
// Package for the comment-skipping tokenizer: scan modes, byte codes,
// result types and the helpers that build results. No dependencies.
`default_nettype none

package cst_pkg;

  localparam int MAX_TOKEN = 256;
  localparam int LEN_W     = $clog2(MAX_TOKEN);
  localparam logic [LEN_W-1:0] TOK_LIMIT = LEN_W'(MAX_TOKEN - 1);

  // Result queue depth; must be a power of two and at least 2.
  localparam int RQ_DEPTH = 4;
  localparam int PTR_W    = $clog2(RQ_DEPTH);
  localparam int CNT_W    = $clog2(RQ_DEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef enum logic [2:0] {
    MODE_SKIP   = 3'd0,
    MODE_WORD   = 3'd1,
    MODE_QUOTED = 3'd2,
    MODE_LINE   = 3'd3,
    MODE_BLOCK  = 3'd4,
    MODE_STAR   = 3'd5
  } mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       token_end;
    logic       was_quoted;
    logic       text_end;
  } res_t;

  // Up to two results produced by one text byte.
  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] cnt;
  } step_t;

  function automatic res_t mk_byte(input logic [7:0] c);
    res_t r;
    r            = '0;
    r.data       = c;
    r.byte_valid = 1'b1;
    return r;
  endfunction

  function automatic res_t mk_end(input logic quoted, input logic tx);
    res_t r;
    r            = '0;
    r.token_end  = 1'b1;
    r.was_quoted = quoted;
    r.text_end   = tx;
    return r;
  endfunction

  function automatic res_t mk_text();
    res_t r;
    r          = '0;
    r.text_end = 1'b1;
    return r;
  endfunction

  function automatic step_t push(input step_t s, input res_t r);
    step_t o;
    o = s;
    if (s.cnt == 2'd0) begin
      o.r0 = r;
    end else begin
      o.r1 = r;
    end
    o.cnt = s.cnt + 2'd1;
    return o;
  endfunction

endpackage

`default_nettype wire

>>> rtl/cst_scan.sv
// Scanner core: mode, held slash and token length registers plus the
// per-byte next-state and result logic. Depends on cst_pkg.
`default_nettype none

`include "comment_skipping_tokenizer_assert.svh"

module cst_scan (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step_en,
  input  wire logic [7:0]    char_byte,
  output cst_pkg::step_t     step
);
  import cst_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic             slash_r, slash_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  always_comb begin
    logic       do_slash;
    logic       do_word;
    logic       do_tok;
    logic       is_ws;
    step_t      s;
    logic [7:0] c;

    c         = char_byte;
    is_ws     = (c != CH_NUL) && (c <= CH_SPACE);
    do_slash  = 1'b0;
    do_word   = 1'b0;
    do_tok    = 1'b0;
    s         = '0;
    mode_nxt  = mode_r;
    slash_nxt = slash_r;
    len_nxt   = len_r;

    case (mode_r)
      MODE_WORD: begin
        if (slash_r) begin
          slash_nxt = 1'b0;
          if (c == CH_SLASH || c == CH_STAR) begin
            mode_nxt = (c == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
            len_nxt  = '0;
            s        = push(s, mk_end(1'b0, 1'b0));
          end else begin
            do_slash = 1'b1;
            do_word  = 1'b1;
          end
        end else begin
          do_word = 1'b1;
        end
      end
      MODE_QUOTED: begin
        if (c == CH_NUL) begin
          mode_nxt = MODE_SKIP;
          len_nxt  = '0;
          s        = push(s, mk_end(1'b1, 1'b1));
        end else if (c == CH_QUOTE) begin
          mode_nxt = MODE_SKIP;
          len_nxt  = '0;
          s        = push(s, mk_end(1'b1, 1'b0));
        end else begin
          do_tok = 1'b1;
        end
      end
      MODE_LINE: begin
        if (c == CH_NUL) begin
          mode_nxt = MODE_SKIP;
          len_nxt  = '0;
          s        = push(s, mk_text());
        end else if (c == CH_LF || c == CH_CR) begin
          mode_nxt = MODE_SKIP;
        end
      end
      MODE_BLOCK, MODE_STAR: begin
        if (c == CH_NUL) begin
          mode_nxt = MODE_SKIP;
          len_nxt  = '0;
          s        = push(s, mk_text());
        end else if (mode_r == MODE_STAR && c == CH_SLASH) begin
          mode_nxt = MODE_SKIP;
        end else begin
          mode_nxt = (c == CH_STAR) ? MODE_STAR : MODE_BLOCK;
        end
      end
      default: begin
        // between tokens; unused codes land here too
        mode_nxt = MODE_SKIP;
        if (slash_r) begin
          slash_nxt = 1'b0;
          if (c == CH_SLASH) begin
            mode_nxt = MODE_LINE;
          end else if (c == CH_STAR) begin
            mode_nxt = MODE_BLOCK;
          end else begin
            mode_nxt = MODE_WORD;
            len_nxt  = '0;
            do_slash = 1'b1;
            do_word  = 1'b1;
          end
        end else if (c == CH_NUL) begin
          len_nxt = '0;
          s       = push(s, mk_text());
        end else if (is_ws) begin
          mode_nxt = MODE_SKIP;
        end else if (c == CH_SLASH) begin
          slash_nxt = 1'b1;
        end else begin
          len_nxt = '0;
          if (c == CH_QUOTE) begin
            mode_nxt = MODE_QUOTED;
          end else begin
            mode_nxt = MODE_WORD;
            do_tok   = 1'b1;
          end
        end
      end
    endcase

    // a held slash that opened no comment becomes the word's next byte
    if (do_slash && len_nxt < TOK_LIMIT) begin
      len_nxt = LEN_W'(len_nxt + 1'b1);
      s       = push(s, mk_byte(CH_SLASH));
    end

    if (do_word) begin
      if (c == CH_NUL || is_ws) begin
        mode_nxt  = MODE_SKIP;
        slash_nxt = 1'b0;
        len_nxt   = '0;
        s         = push(s, mk_end(1'b0, c == CH_NUL));
      end else if (c == CH_SLASH) begin
        slash_nxt = 1'b1;
      end else begin
        do_tok = 1'b1;
      end
    end

    if (do_tok && len_nxt < TOK_LIMIT) begin
      len_nxt = LEN_W'(len_nxt + 1'b1);
      s       = push(s, mk_byte(c));
    end

    step = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SKIP;
      slash_r <= 1'b0;
      len_r   <= '0;
    end else if (step_en) begin
      mode_r  <= mode_nxt;
      slash_r <= slash_nxt;
      len_r   <= len_nxt;
    end
  end

  `CST_ASSERT_ALWAYS(a_slash_mode, clk, rst_n,
    !slash_r || mode_r == MODE_WORD || mode_r == MODE_SKIP)
  `CST_ASSERT_ALWAYS(a_pair_leads_byte, clk, rst_n,
    step.cnt != 2'd2 || (step.r0.byte_valid && step.r0.data == CH_SLASH))

endmodule

`default_nettype wire

>>> rtl/cst_fifo.sv
// Result queue: small register FIFO taking up to two results per cycle
// and giving one. Depends on cst_pkg.
`default_nettype none

`include "comment_skipping_tokenizer_assert.svh"

module cst_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cst_pkg::step_t push_step,
  input  wire logic          push_en,
  input  wire logic          pop,
  output cst_pkg::res_t      head,
  output logic               not_empty,
  output logic               room2
);
  import cst_pkg::*;

  res_t             mem [RQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       push_cnt;
  logic [PTR_W-1:0] wr_ptr_p1;

  assign push_cnt   = push_en ? push_step.cnt : 2'd0;
  assign wr_ptr_p1  = PTR_W'(wr_ptr_r + 1'b1);
  assign wr_ptr_nxt = PTR_W'(wr_ptr_r + push_cnt);
  assign rd_ptr_nxt = pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
  assign cnt_nxt    = CNT_W'(cnt_r + CNT_W'(push_cnt) - CNT_W'(pop));

  assign head      = mem[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign room2     = (cnt_r <= CNT_W'(RQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push_step.r0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push_step.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `CST_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(RQ_DEPTH))
  `CST_ASSERT_ALWAYS(a_no_overflow, clk, rst_n,
    (CNT_W'(push_cnt) + cnt_r) <= CNT_W'(RQ_DEPTH))
  `CST_ASSERT_NEXT(a_ptr_track, clk, rst_n, 1'b1,
    PTR_W'(wr_ptr_r - rd_ptr_r) == PTR_W'(cnt_r))

endmodule

`default_nettype wire

>>> rtl/comment_skipping_tokenizer.sv
// Top level of the comment-skipping tokenizer: input register, scanner core
// and result queue. Depends on cst_pkg, cst_scan and cst_fifo.
// A result passes through the input register and the result queue to the output.
// Throughput: one text byte per cycle while the queue has room for two results;
// one result per cycle leaves while out_tready is high; a byte yielding two results
// (a held slash that turns into a word byte) is absorbed by the four-entry queue.
// Reset (synchronous, rst_n low): scanner returns between tokens, queue empties.
`default_nettype none

module comment_skipping_tokenizer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] char_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast,  // token_end
  output logic [2:0]      out_tuser   // [0] byte_valid, [1] was_quoted, [2] text_end
);
  import cst_pkg::*;

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] char_r;
  logic       in_take;
  logic       step_fire;
  logic       room2;
  logic       q_not_empty;
  logic       pop;
  step_t      step;
  res_t       head;

  assign step_fire = in_vld_r && room2;
  assign in_tready = !in_vld_r || step_fire;
  assign in_take   = in_tvalid && in_tready;
  assign in_vld_nxt = in_take ? 1'b1 : (step_fire ? 1'b0 : in_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      char_r <= in_tdata;
    end
  end

  cst_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_fire),
    .char_byte (char_r),
    .step      (step)
  );

  cst_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_step (step),
    .push_en   (step_fire),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .room2     (room2)
  );

  assign pop        = q_not_empty && out_tready;
  assign out_tvalid = q_not_empty;
  assign out_tdata  = head.data;
  assign out_tlast  = head.token_end;
  assign out_tuser  = {head.text_end, head.was_quoted, head.byte_valid};

endmodule

`default_nettype wire
